// ----- design/qstm_pkg.sv -----
// qstm_pkg: widths, fixed-point constants and product indexes for the
// quaternion/scale/translation to affine matrix pipeline; no dependencies
`default_nettype none

package qstm_pkg;

   localparam int QUAT_W  = 16;                 // Q2.14 quaternion component
   localparam int SCL_W   = 16;                 // Q4.12 axis scale
   localparam int TRN_W   = 32;                 // Q16.16 translation
   localparam int ENT_W   = 16;                 // Q4.12 matrix entry
   localparam int PROD_W  = 2 * QUAT_W;         // a*b, exact
   localparam int TERM_W  = PROD_W + 2;         // sums of doubled products, Q.28
   localparam int MUL_W   = TERM_W + SCL_W;     // term * scale, Q.40
   localparam int RND_W   = MUL_W + 1;          // after rounding offset
   localparam int Q_SHIFT = 28;                 // Q.40 -> Q4.12
   localparam int SHR_W   = RND_W - Q_SHIFT;    // width after the shift

   localparam int N_PROD  = 9;
   localparam int N_ENT   = 9;
   localparam int N_AXIS  = 3;

   localparam logic signed [TERM_W-1:0] ONE_Q28  = TERM_W'(64'sd1 <<< Q_SHIFT);
   localparam logic signed [RND_W-1:0]  HALF_Q28 = RND_W'(64'sd1 <<< (Q_SHIFT - 1));
   localparam logic signed [SHR_W-1:0]  SAT_MAX  = SHR_W'(32767);
   localparam logic signed [SHR_W-1:0]  SAT_MIN  = SHR_W'(-32768);

   // quaternion product slots
   localparam int P_XX = 0;
   localparam int P_YY = 1;
   localparam int P_ZZ = 2;
   localparam int P_XY = 3;
   localparam int P_XZ = 4;
   localparam int P_YZ = 5;
   localparam int P_WX = 6;
   localparam int P_WY = 7;
   localparam int P_WZ = 8;

   localparam int N_STG = 4;

endpackage

`default_nettype wire

// ----- design/quat_scale_translate_to_matrix.sv -----
// quat_scale_translate_to_matrix: four-stage pipeline from rotation quaternion,
// axis scale and translation to the twelve variable affine matrix entries
// depends on qstm_pkg
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  quat_x..w, scale_x..z, trans_x..z
//   rsp_      out         rsp_valid / rsp_stall  m00..m22 (Q4.12), m30..m32 (Q16.16)
//
// one word per cycle sustained while rsp_stall is low; four register stages:
// quaternion products, doubled sums, scale multiply, round/saturate
// reset (synchronous, active high) empties the pipeline, data registers are not cleared
// each stage moves when the next is empty or moving, so bubbles close up under stall;
// req_stall rises only when all four stages hold words and rsp_stall is high
`default_nettype none

module quat_scale_translate_to_matrix
   import qstm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic signed [QUAT_W-1:0] req_quat_x,
   input  wire logic signed [QUAT_W-1:0] req_quat_y,
   input  wire logic signed [QUAT_W-1:0] req_quat_z,
   input  wire logic signed [QUAT_W-1:0] req_quat_w,
   input  wire logic signed [SCL_W-1:0]  req_scale_x,
   input  wire logic signed [SCL_W-1:0]  req_scale_y,
   input  wire logic signed [SCL_W-1:0]  req_scale_z,
   input  wire logic signed [TRN_W-1:0]  req_trans_x,
   input  wire logic signed [TRN_W-1:0]  req_trans_y,
   input  wire logic signed [TRN_W-1:0]  req_trans_z,

   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic signed [ENT_W-1:0]  rsp_m00,
   output      logic signed [ENT_W-1:0]  rsp_m01,
   output      logic signed [ENT_W-1:0]  rsp_m02,
   output      logic signed [ENT_W-1:0]  rsp_m10,
   output      logic signed [ENT_W-1:0]  rsp_m11,
   output      logic signed [ENT_W-1:0]  rsp_m12,
   output      logic signed [ENT_W-1:0]  rsp_m20,
   output      logic signed [ENT_W-1:0]  rsp_m21,
   output      logic signed [ENT_W-1:0]  rsp_m22,
   output      logic signed [TRN_W-1:0]  rsp_m30,
   output      logic signed [TRN_W-1:0]  rsp_m31,
   output      logic signed [TRN_W-1:0]  rsp_m32
);

   logic [N_STG-1:0] stg_valid_ff;
   logic [N_STG-1:0] stg_valid_in;
   logic [N_STG-1:0] stg_en;

   // stage 1: products
   logic signed [PROD_W-1:0] s1_prod_ff  [N_PROD];
   logic signed [PROD_W-1:0] s1_prod_in  [N_PROD];
   logic signed [SCL_W-1:0]  s1_scale_ff [N_AXIS];
   logic signed [TRN_W-1:0]  s1_trans_ff [N_AXIS];

   // stage 2: rotation terms, Q.28
   logic signed [TERM_W-1:0] dbl         [N_PROD];
   logic signed [TERM_W-1:0] s2_term_ff  [N_ENT];
   logic signed [TERM_W-1:0] s2_term_in  [N_ENT];
   logic signed [SCL_W-1:0]  s2_scale_ff [N_AXIS];
   logic signed [TRN_W-1:0]  s2_trans_ff [N_AXIS];

   // stage 3: scaled terms, Q.40
   logic signed [MUL_W-1:0]  s3_mul_ff   [N_ENT];
   logic signed [MUL_W-1:0]  s3_mul_in   [N_ENT];
   logic signed [TRN_W-1:0]  s3_trans_ff [N_AXIS];

   // stage 4: rounded, saturated entries
   logic signed [RND_W-1:0]  rnd         [N_ENT];
   logic signed [SHR_W-1:0]  shr         [N_ENT];
   logic signed [ENT_W-1:0]  s4_ent_ff   [N_ENT];
   logic signed [ENT_W-1:0]  s4_ent_in   [N_ENT];
   logic signed [TRN_W-1:0]  s4_trans_ff [N_AXIS];

   // a stage loads when it is empty or its word moves on
   always_comb begin
      stg_en[N_STG-1] = !stg_valid_ff[N_STG-1] || !rsp_stall;
      for (int k = N_STG - 2; k >= 0; k--) begin
         stg_en[k] = !stg_valid_ff[k] || stg_en[k+1];
      end
   end

   assign req_stall = !stg_en[0];

   always_comb begin
      stg_valid_in[0] = req_valid;
      for (int k = 1; k < N_STG; k++) begin
         stg_valid_in[k] = stg_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         for (int k = 0; k < N_STG; k++) begin
            if (stg_en[k]) begin
               stg_valid_ff[k] <= stg_valid_in[k];
            end
         end
      end
   end

   // stage 1
   always_comb begin
      s1_prod_in[P_XX] = req_quat_x * req_quat_x;
      s1_prod_in[P_YY] = req_quat_y * req_quat_y;
      s1_prod_in[P_ZZ] = req_quat_z * req_quat_z;
      s1_prod_in[P_XY] = req_quat_x * req_quat_y;
      s1_prod_in[P_XZ] = req_quat_x * req_quat_z;
      s1_prod_in[P_YZ] = req_quat_y * req_quat_z;
      s1_prod_in[P_WX] = req_quat_w * req_quat_x;
      s1_prod_in[P_WY] = req_quat_w * req_quat_y;
      s1_prod_in[P_WZ] = req_quat_w * req_quat_z;
   end

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         s1_prod_ff     <= s1_prod_in;
         s1_scale_ff[0] <= req_scale_x;
         s1_scale_ff[1] <= req_scale_y;
         s1_scale_ff[2] <= req_scale_z;
         s1_trans_ff[0] <= req_trans_x;
         s1_trans_ff[1] <= req_trans_y;
         s1_trans_ff[2] <= req_trans_z;
      end
   end

   // stage 2: doubling is a one-bit shift, sums cannot overflow TERM_W
   always_comb begin
      for (int i = 0; i < N_PROD; i++) begin
         dbl[i] = $signed({s1_prod_ff[i][PROD_W-1], s1_prod_ff[i], 1'b0});
      end
      s2_term_in[0] = ONE_Q28 - (dbl[P_YY] + dbl[P_ZZ]);
      s2_term_in[1] = dbl[P_XY] + dbl[P_WZ];
      s2_term_in[2] = dbl[P_XZ] - dbl[P_WY];
      s2_term_in[3] = dbl[P_XY] - dbl[P_WZ];
      s2_term_in[4] = ONE_Q28 - (dbl[P_XX] + dbl[P_ZZ]);
      s2_term_in[5] = dbl[P_YZ] + dbl[P_WX];
      s2_term_in[6] = dbl[P_XZ] + dbl[P_WY];
      s2_term_in[7] = dbl[P_YZ] - dbl[P_WX];
      s2_term_in[8] = ONE_Q28 - (dbl[P_XX] + dbl[P_YY]);
   end

   always_ff @(posedge clock) begin
      if (stg_en[1]) begin
         s2_term_ff  <= s2_term_in;
         s2_scale_ff <= s1_scale_ff;
         s2_trans_ff <= s1_trans_ff;
      end
   end

   // stage 3: row r takes the scale of axis r
   always_comb begin
      for (int i = 0; i < N_ENT; i++) begin
         s3_mul_in[i] = MUL_W'(s2_term_ff[i] * s2_scale_ff[i / N_AXIS]);
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[2]) begin
         s3_mul_ff   <= s3_mul_in;
         s3_trans_ff <= s2_trans_ff;
      end
   end

   // stage 4: round half up, floor shift, clamp
   always_comb begin
      for (int i = 0; i < N_ENT; i++) begin
         rnd[i] = $signed({s3_mul_ff[i][MUL_W-1], s3_mul_ff[i]}) + HALF_Q28;
         shr[i] = rnd[i][RND_W-1:Q_SHIFT];
         if (shr[i] > SAT_MAX) begin
            s4_ent_in[i] = ENT_W'(SAT_MAX);
         end else if (shr[i] < SAT_MIN) begin
            s4_ent_in[i] = ENT_W'(SAT_MIN);
         end else begin
            s4_ent_in[i] = shr[i][ENT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[3]) begin
         s4_ent_ff   <= s4_ent_in;
         s4_trans_ff <= s3_trans_ff;
      end
   end

   assign rsp_valid = stg_valid_ff[N_STG-1];
   assign rsp_m00   = s4_ent_ff[0];
   assign rsp_m01   = s4_ent_ff[1];
   assign rsp_m02   = s4_ent_ff[2];
   assign rsp_m10   = s4_ent_ff[3];
   assign rsp_m11   = s4_ent_ff[4];
   assign rsp_m12   = s4_ent_ff[5];
   assign rsp_m20   = s4_ent_ff[6];
   assign rsp_m21   = s4_ent_ff[7];
   assign rsp_m22   = s4_ent_ff[8];
   assign rsp_m30   = s4_trans_ff[0];
   assign rsp_m31   = s4_trans_ff[1];
   assign rsp_m32   = s4_trans_ff[2];

   // input backs up only with every stage full and the output stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&stg_valid_ff) && rsp_stall)
      else $error("req_stall with room in the pipeline");

   // an accepted word lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stg_valid_ff[0])
      else $error("accepted word lost at stage 1");

   // a held word in a middle stage is not dropped
   a_hold_mid: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff[1] && !stg_en[1]) |=> stg_valid_ff[1])
      else $error("stalled word dropped in stage 2");

   a_hold_mid3: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff[2] && !stg_en[2]) |=> stg_valid_ff[2])
      else $error("stalled word dropped in stage 3");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for quat_scale_translate_to_matrix: sends transform words
// and checks each matrix word against a built-in fixed-point predictor
// depends on qstm_pkg and the block's rtl
`timescale 1ns / 1ps

module testbench
   import qstm_pkg::*;
();

   localparam int CLK_PERIOD = 8;

   typedef struct packed {
      logic signed [QUAT_W-1:0] qx;
      logic signed [QUAT_W-1:0] qy;
      logic signed [QUAT_W-1:0] qz;
      logic signed [QUAT_W-1:0] qw;
      logic signed [SCL_W-1:0]  sx;
      logic signed [SCL_W-1:0]  sy;
      logic signed [SCL_W-1:0]  sz;
      logic signed [TRN_W-1:0]  tx;
      logic signed [TRN_W-1:0]  ty;
      logic signed [TRN_W-1:0]  tz;
   } xform_type;

   // rot[0..8] = m00 m01 m02 m10 m11 m12 m20 m21 m22, tr[0..2] = m30 m31 m32
   typedef struct packed {
      logic [N_ENT-1:0][ENT_W-1:0]  rot;
      logic [N_AXIS-1:0][TRN_W-1:0] tr;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid = 1'b0;
   logic      req_stall;
   xform_type req_word  = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic signed [ENT_W-1:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [ENT_W-1:0] rsp_m20, rsp_m21, rsp_m22;
   logic signed [TRN_W-1:0] rsp_m30, rsp_m31, rsp_m32;

   xform_type  xform_q[$];
   matrix_type matrix_q[$];

   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;
   int unsigned gap_left  = 0;
   int unsigned stall_left = 0;
   bit          quiet     = 1'b0;
   int          mismatches = 0;
   int          words_seen = 0;

   string rot_name [N_ENT]  = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
   string tr_name  [N_AXIS] = '{"m30", "m31", "m32"};

   always #(CLK_PERIOD / 2) clock = ~clock;

   quat_scale_translate_to_matrix u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_quat_x  (req_word.qx),
      .req_quat_y  (req_word.qy),
      .req_quat_z  (req_word.qz),
      .req_quat_w  (req_word.qw),
      .req_scale_x (req_word.sx),
      .req_scale_y (req_word.sy),
      .req_scale_z (req_word.sz),
      .req_trans_x (req_word.tx),
      .req_trans_y (req_word.ty),
      .req_trans_z (req_word.tz),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_m00     (rsp_m00),
      .rsp_m01     (rsp_m01),
      .rsp_m02     (rsp_m02),
      .rsp_m10     (rsp_m10),
      .rsp_m11     (rsp_m11),
      .rsp_m12     (rsp_m12),
      .rsp_m20     (rsp_m20),
      .rsp_m21     (rsp_m21),
      .rsp_m22     (rsp_m22),
      .rsp_m30     (rsp_m30),
      .rsp_m31     (rsp_m31),
      .rsp_m32     (rsp_m32)
   );

   // Q.28 term times Q4.12 scale, round half up, clamp to Q4.12
   function automatic logic signed [ENT_W-1:0] round_sat(longint term, longint scl);
      longint r;
      r = (term * scl + longint'(HALF_Q28)) >>> Q_SHIFT;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return ENT_W'(r);
   endfunction

   function automatic matrix_type xform_to_matrix(xform_type t);
      longint     one;
      longint     x, y, z, w;
      longint     xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint     s [N_AXIS];
      longint     term [N_ENT];
      matrix_type m;
      one  = longint'(ONE_Q28);
      x    = longint'(t.qx);
      y    = longint'(t.qy);
      z    = longint'(t.qz);
      w    = longint'(t.qw);
      s[0] = longint'(t.sx);
      s[1] = longint'(t.sy);
      s[2] = longint'(t.sz);
      xx = 2 * x * x;
      yy = 2 * y * y;
      zz = 2 * z * z;
      xy = 2 * x * y;
      xz = 2 * x * z;
      yz = 2 * y * z;
      wx = 2 * w * x;
      wy = 2 * w * y;
      wz = 2 * w * z;
      term[0] = one - (yy + zz);
      term[1] = xy + wz;
      term[2] = xz - wy;
      term[3] = xy - wz;
      term[4] = one - (xx + zz);
      term[5] = yz + wx;
      term[6] = xz + wy;
      term[7] = yz - wx;
      term[8] = one - (xx + yy);
      for (int i = 0; i < N_ENT; i++)
         m.rot[i] = round_sat(term[i], s[i / N_AXIS]);
      m.tr[0] = t.tx;
      m.tr[1] = t.ty;
      m.tr[2] = t.tz;
      return m;
   endfunction

   task automatic flag_mismatch(string msg);
      $display("mismatch at result word %0d: %s", words_seen, msg);
      mismatches++;
   endtask

   // sender: a new word goes out only once the previous one was taken
   always @(posedge clock) begin : drive_req
      xform_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall)
            matrix_q.push_back(xform_to_matrix(req_word));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0 && !quiet) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (xform_q.size() != 0 && !quiet && $urandom_range(99) < gap_pct) begin
               req_valid <= 1'b0;
               gap_left  <= $urandom_range(0, 11);
            end else if (xform_q.size() != 0) begin
               nxt = xform_q.pop_front();
               req_word  <= nxt;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall bursts and result check
   always @(posedge clock) begin : watch_rsp
      matrix_type seen;
      matrix_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (stall_left != 0 && !quiet) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!quiet && $urandom_range(99) < stall_pct) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 11);
         end else begin
            rsp_stall <= 1'b0;
         end

         if (rsp_valid && !rsp_stall) begin
            seen.rot = {rsp_m22, rsp_m21, rsp_m20, rsp_m12, rsp_m11, rsp_m10,
                        rsp_m02, rsp_m01, rsp_m00};
            seen.tr  = {rsp_m32, rsp_m31, rsp_m30};
            if (matrix_q.size() == 0) begin
               flag_mismatch("result word with nothing expected");
            end else begin
               want = matrix_q.pop_front();
               for (int i = 0; i < N_ENT; i++)
                  if (seen.rot[i] !== want.rot[i])
                     flag_mismatch($sformatf("%s got %0d expected %0d", rot_name[i],
                                   $signed(seen.rot[i]), $signed(want.rot[i])));
               for (int i = 0; i < N_AXIS; i++)
                  if (seen.tr[i] !== want.tr[i])
                     flag_mismatch($sformatf("%s got %0d expected %0d", tr_name[i],
                                   $signed(seen.tr[i]), $signed(want.tr[i])));
            end
            words_seen++;
         end
      end
   end

   task automatic push_xform(input logic signed [QUAT_W-1:0] qx, qy, qz, qw,
                             input logic signed [SCL_W-1:0] sx, sy, sz,
                             input logic signed [TRN_W-1:0] tx, ty, tz);
      xform_type t;
      t = '{qx, qy, qz, qw, sx, sy, sz, tx, ty, tz};
      xform_q.push_back(t);
   endtask

   function automatic logic signed [QUAT_W-1:0] quat_edge();
      int v [7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
      return QUAT_W'(v[$urandom_range(0, 6)]);
   endfunction

   function automatic logic signed [SCL_W-1:0] random_scale();
      int v [7] = '{-32768, -4096, -1, 0, 1, 4096, 32767};
      int m;
      m = $urandom_range(0, 9);
      if (m < 5)
         return SCL_W'($urandom_range(1) ? -int'($urandom_range(0, 8192))
                                         : int'($urandom_range(0, 8192)));
      if (m < 8)
         return SCL_W'($urandom);
      return SCL_W'(v[$urandom_range(0, 6)]);
   endfunction

   // half unit quaternions, the rest in-range, raw bits or corner values
   function automatic xform_type random_xform();
      real       a [4];
      real       n;
      int        q [4];
      int        m;
      xform_type t;
      m = $urandom_range(0, 19);
      if (m < 10) begin
         n = 0.0;
         for (int i = 0; i < 4; i++) begin
            a[i] = real'(int'($urandom_range(0, 2000000)) - 1000000);
            n = n + a[i] * a[i];
         end
         n = $sqrt(n);
         if (n < 1.0) n = 1.0;
         for (int i = 0; i < 4; i++)
            q[i] = $rtoi(a[i] / n * 16384.0);
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (m < 15)
               q[i] = int'($urandom_range(0, 32768)) - 16384;
            else if (m < 18)
               q[i] = int'($urandom_range(0, 65535)) - 32768;
            else
               q[i] = int'(quat_edge());
         end
      end
      t.qx = QUAT_W'(q[0]);
      t.qy = QUAT_W'(q[1]);
      t.qz = QUAT_W'(q[2]);
      t.qw = QUAT_W'(q[3]);
      t.sx = random_scale();
      t.sy = random_scale();
      t.sz = random_scale();
      t.tx = $urandom;
      t.ty = $urandom;
      t.tz = $urandom;
      return t;
   endfunction

   task automatic wait_drained();
      while (xform_q.size() != 0 || req_valid || matrix_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin : run_stimulus
      int unsigned gap_mix   [5] = '{25, 0, 10, 0, 40};
      int unsigned stall_mix [5] = '{0, 30, 10, 0, 40};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corner transforms
      push_xform(0, 0, 0, 16384, 4096, 4096, 4096, 0, 0, 0);
      push_xform(0, 0, 0, 16384, 4096, 4096, 4096,
                 32'sh8000_0000, 32'sh7fff_ffff, -1);
      push_xform(11585, 0, 0, 11585, 4096, 8192, -4096, 32'sh0001_0000, 0, 1);
      push_xform(0, 11585, 0, 11585, 4096, 4096, 4096, 0, -65536, 0);
      push_xform(0, 0, 11585, 11585, 4096, 4096, 4096, 0, 0, 12345);
      push_xform(16384, 0, 0, 0, 4096, 4096, 4096, 0, 0, 0);
      push_xform(0, 0, 0, -16384, 4096, 4096, 4096, 0, 0, 0);
      push_xform(8192, 8192, 8192, 8192, 4096, -4096, 2048, 1, 2, 3);
      // non-unit quaternions saturate
      push_xform(-16384, -16384, -16384, -16384, 32767, 32767, 32767, 0, 0, 0);
      push_xform(16384, 16384, 16384, 16384, -32768, -32768, -32768, 0, 0, 0);
      push_xform(-32768, -32768, -32768, -32768, 32767, -32768, 1, 0, 0, 0);
      push_xform(32767, 32767, 32767, 32767, -32768, 32767, -1, 0, 0, 0);
      push_xform(-32768, 32767, -32768, 32767, 4096, 4096, 4096, 0, 0, 0);
      push_xform(0, 0, 0, 0, 32767, -32768, 0, 0, 0, 0);
      // scale extremes and rounding
      push_xform(0, 0, 0, 16384, -32768, 32767, 0,
                 32'sh7fff_ffff, 32'sh8000_0000, 0);
      push_xform(5793, -3000, 12000, -9000, 1, -1, 1, -1, -1, -1);
      push_xform(16'sh5555, 16'sh2aaa, 16'sh5555, 16'sh2aaa, 16'sh5555, 16'sh2aaa,
                 16'sh5555, 32'sh5555_5555, 32'sh2aaa_aaaa, 32'sh5555_5555);
      push_xform(16'shaaaa, 16'shd555, 16'shaaaa, 16'shd555, 16'shaaaa, 16'shd555,
                 16'shaaaa, 32'shaaaa_aaaa, 32'shd555_5555, 32'shaaaa_aaaa);
      push_xform(-11585, 0, 0, 11585, 32767, 32767, 32767, 0, 0, 0);
      push_xform(100, -200, 300, 16380, -2, 3, -5, 7, -7, 7);
      wait_drained();

      for (int r = 0; r < 5; r++) begin
         gap_pct   = gap_mix[r];
         stall_pct = stall_mix[r];
         for (int i = 0; i < 250; i++)
            xform_q.push_back(random_xform());
         // rounds 1 and 3 wait until every queued word has been sent and checked
         if (r == 1 || r == 3)
            wait_drained();
      end

      // back-to-back at full rate to finish
      wait_drained();
      quiet = 1'b1;
      for (int i = 0; i < 80; i++)
         xform_q.push_back(random_xform());
      wait_drained();

      repeat (4 * N_STG) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
